/* hdl/ffca_pkg.sv */
// ----------------------------------------------------------------------------
// First-fit capacity allocator package
// Shared sizes, command codes and sequencer states of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

  // Tree shape: one leaf per slot, heap numbered from node one.
  localparam int unsigned LEVELS     = 10;
  localparam int unsigned SLOT_COUNT = 1 << LEVELS;
  localparam int unsigned SLOT_W     = LEVELS;
  localparam int unsigned NODE_W     = LEVELS + 1;
  localparam int unsigned MEM_DEPTH  = 2 * SLOT_COUNT;

  // Field widths.
  localparam int unsigned CAP_W    = 32;
  localparam int unsigned ACTIVE_W = 11;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(SLOT_COUNT);

  // Stream data widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = ((SLOT_W + CAP_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;

  // Command codes carried in the input tuser.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_LEAF,
    ST_UP
  } state_e;

endpackage

`default_nettype wire

/* hdl/first_fit_capacity_allocator.sv */
// ----------------------------------------------------------------------------
// First-fit capacity allocator
// Keeps per-slot capacities with a max tree over them in one memory, finds the
// lowest active slot that fits a request and charges it.
// ----------------------------------------------------------------------------
// A request walks down the tree to a leaf and registers its result at the leaf check.
// A hit then charges the leaf and rebuilds the maxima on the way back up; a miss returns
// to idle. The tree memory has one read and one write port.
// One item at a time; a load writes its leaf and rebuilds its path. The tree is walked one level per
// cycle, down then up, but the leaf check waits while an earlier result waits on m_axis_tready.
// Reset is asynchronous, active low; the slot store is undefined until loaded.
`default_nettype none

module first_fit_capacity_allocator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration: number of active slots.
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ffca_pkg::ACTIVE_W-1:0]      cfg_data_i,
  // Input stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: slot_number [9:0], amount [41:10], zero padding up to bit 47.
  input  wire logic [ffca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: command.
  input  wire logic                               s_axis_tuser,
  // Output stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: chosen_slot [9:0], zero padding up to bit 15.
  output logic [ffca_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // tuser: found.
  output logic                                    m_axis_tuser
);

  localparam int unsigned LEVELS = ffca_pkg::LEVELS;
  localparam int unsigned NODE_W = ffca_pkg::NODE_W;
  localparam int unsigned SLOT_W = ffca_pkg::SLOT_W;
  localparam int unsigned CAP_W  = ffca_pkg::CAP_W;

  // Input field unpacking.
  logic [SLOT_W-1:0] in_slot;
  logic [CAP_W-1:0]  in_amount;
  assign in_slot   = s_axis_tdata[SLOT_W-1:0];
  assign in_amount = s_axis_tdata[SLOT_W+CAP_W-1:SLOT_W];

  // Registers.
  ffca_pkg::state_e              state_q, state_d;
  logic [NODE_W-1:0]             node_q, node_d;
  logic [CAP_W-1:0]              amt_q, amt_d;
  logic [CAP_W-1:0]              val_q, val_d;
  logic [ffca_pkg::ACTIVE_W-1:0] active_q;
  logic                          out_valid_q, out_valid_d;
  logic                          found_q, found_d;
  logic [SLOT_W-1:0]             slot_q, slot_d;

  // Memory port signals.
  logic [CAP_W-1:0]  mem [ffca_pkg::MEM_DEPTH];
  logic [CAP_W-1:0]  rdata_q;
  logic [NODE_W-1:0] raddr;
  logic              we;
  logic [NODE_W-1:0] waddr;
  logic [CAP_W-1:0]  wdata;

  // Shared compare and arithmetic unit.
  logic              fits;
  logic [CAP_W-1:0]  diff;
  logic [CAP_W-1:0]  upper;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] parent;
  logic [SLOT_W-1:0] leaf_slot;
  logic              leaf_active;
  logic              can_emit;
  logic              in_fire;

  assign fits        = rdata_q >= amt_q;
  assign diff        = rdata_q - amt_q;
  assign upper       = (rdata_q > val_q) ? rdata_q : val_q;
  assign next_node   = {node_q[NODE_W-2:0], ~fits};
  assign parent      = {1'b0, node_q[NODE_W-1:1]};
  assign leaf_slot   = node_q[SLOT_W-1:0];
  assign leaf_active = {1'b0, leaf_slot} < active_q;
  assign can_emit    = !out_valid_q || m_axis_tready;
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ffca_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Tree memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ffca_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // Sequencer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffca_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      node_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      node_q      <= node_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q   <= amt_d;
    val_q   <= val_d;
    found_q <= found_d;
    slot_q  <= slot_d;
  end

  // Next state, memory control and result.
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    amt_d       = amt_q;
    val_d       = val_q;
    found_d     = found_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    raddr       = '0;
    we          = 1'b0;
    waddr       = node_q;
    wdata       = val_q;

    case (state_q)
      ffca_pkg::ST_IDLE: begin
        if (in_fire) begin
          amt_d = in_amount;
          if (s_axis_tuser == ffca_pkg::CMD_REQUEST) begin
            // Start at the root and look at its left child.
            node_d  = NODE_W'(1);
            raddr   = NODE_W'(2);
            state_d = ffca_pkg::ST_DESC;
          end else begin
            // Write the leaf, then rebuild the maxima on its path.
            node_d  = {1'b1, in_slot};
            val_d   = in_amount;
            we      = 1'b1;
            waddr   = {1'b1, in_slot};
            wdata   = in_amount;
            raddr   = {1'b1, in_slot[SLOT_W-1:1], ~in_slot[0]};
            state_d = ffca_pkg::ST_UP;
          end
        end
      end

      ffca_pkg::ST_DESC: begin
        // Go left when the left subtree holds a fit, else go right.
        node_d = next_node;
        if (next_node[NODE_W-1]) begin
          raddr   = next_node;
          state_d = ffca_pkg::ST_LEAF;
        end else begin
          raddr = {next_node[NODE_W-2:0], 1'b0};
        end
      end

      ffca_pkg::ST_LEAF: begin
        // Hold the leaf read while the previous result is still waiting.
        raddr = node_q;
        if (can_emit) begin
          out_valid_d = 1'b1;
          if (fits && leaf_active) begin
            found_d = 1'b1;
            slot_d  = leaf_slot;
            val_d   = diff;
            we      = 1'b1;
            waddr   = node_q;
            wdata   = diff;
            raddr   = {node_q[NODE_W-1:1], ~node_q[0]};
            state_d = ffca_pkg::ST_UP;
          end else begin
            found_d = 1'b0;
            slot_d  = '0;
            state_d = ffca_pkg::ST_IDLE;
          end
        end
      end

      ffca_pkg::ST_UP: begin
        // Parent takes the larger of this node and its sibling.
        val_d  = upper;
        we     = 1'b1;
        waddr  = parent;
        wdata  = upper;
        node_d = parent;
        raddr  = {parent[NODE_W-1:1], ~parent[0]};
        if (parent == NODE_W'(1)) begin
          state_d = ffca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ffca_pkg::ST_IDLE;
      end
    endcase
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = ffca_pkg::OUT_DATA_W'(slot_q);

`ifndef ASSERT_OFF
  // A result only appears right after a leaf check.
  a_result_from_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ffca_pkg::ST_LEAF))
    else $error("result raised outside the leaf check");

  // A charged slot is always an active slot.
  a_found_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> ({1'b0, slot_q} < active_q))
    else $error("charged slot beyond the active count");

  // A miss reports slot zero.
  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (slot_q == '0))
    else $error("miss with a nonzero slot");

  // The walk never points at the unused node zero while busy.
  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ffca_pkg::ST_IDLE) |-> (node_q != '0))
    else $error("tree walk at node zero");

  // The leaf check only runs on a leaf node.
  a_leaf_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffca_pkg::ST_LEAF) |-> node_q[LEVELS])
    else $error("leaf check above the leaf level");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// First-fit capacity allocator testbench
// Fills every slot, then runs directed and random load and request traffic
// against a scoreboard that tracks the capacities and the active slot count
// and predicts each grant. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS     = ffca_pkg::LEVELS;
  localparam int unsigned SLOT_COUNT = ffca_pkg::SLOT_COUNT;
  localparam int unsigned SLOT_W     = ffca_pkg::SLOT_W;
  localparam int unsigned CAP_W      = ffca_pkg::CAP_W;
  localparam int unsigned ACTIVE_W   = ffca_pkg::ACTIVE_W;
  localparam int unsigned IN_DATA_W  = ffca_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = ffca_pkg::OUT_DATA_W;

  localparam int unsigned DRAIN_CYCLES = 2 * LEVELS + 10;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned IDLE_PCT     = 12;
  localparam int unsigned RUN_ITEMS    = 72;

  // One grant as it leaves the block.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [ACTIVE_W-1:0]   cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Scoreboard state: capacities, active count and grants still owed.
  logic [CAP_W-1:0]      slot_cap [SLOT_COUNT];
  logic [ACTIVE_W-1:0]   active_count;
  grant_t                grant_q [$];
  int unsigned           mismatch_count;
  int unsigned           cycle_count;
  logic                  quiet;

  first_fit_capacity_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Run length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side back-pressure, dropped during quiet stretches.
  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // Compare each accepted grant with the oldest one owed.
  always @(posedge clk_i) begin
    grant_t exp_grant;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0b tdata=0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count <= mismatch_count + 1;
      end else begin
        exp_grant = grant_q.pop_front();
        if (m_axis_tuser !== exp_grant.found ||
            m_axis_tdata !== OUT_DATA_W'(exp_grant.slot)) begin
          $display("%0t: grant mismatch: expected found=%0b slot=%0d, actual found=%0b tdata=0x%0h",
                   $time, exp_grant.found, exp_grant.slot, m_axis_tuser, m_axis_tdata);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Number of slots that can match; counts above the slot total saturate.
  function automatic int unsigned usable_slots();
    return (active_count > SLOT_COUNT) ? SLOT_COUNT : int'(active_count);
  endfunction

  // Apply one accepted item to the scoreboard and queue the grant it owes.
  task automatic apply_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input logic [CAP_W-1:0] amount);
    grant_t      grant;
    int unsigned lim;
    if (cmd == ffca_pkg::CMD_LOAD) begin
      slot_cap[slot] = amount;
    end else begin
      grant = '0;
      lim   = usable_slots();
      for (int unsigned i = 0; i < lim; i++) begin
        if (slot_cap[i] >= amount) begin
          slot_cap[i]  = slot_cap[i] - amount;
          grant.found  = 1'b1;
          grant.slot   = SLOT_W'(i);
          break;
        end
      end
      grant_q.push_back(grant);
    end
  endtask

  // Send one item and wait for its transaction.
  task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [CAP_W-1:0] amount);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= IN_DATA_W'({amount, slot});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_item(cmd, slot, amount);
  endtask

  // Stop sending, wait for all grants, then let a load finish inside.
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the active slot count while the block is idle.
  task automatic write_active_count(input logic [ACTIVE_W-1:0] value);
    wait_for_drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    active_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Capacities trend upward with the slot number, with rare full-range and zero values.
  function automatic logic [CAP_W-1:0] pick_capacity(input int unsigned slot);
    int unsigned sel;
    sel = $urandom_range(31, 0);
    if (sel == 0) return $urandom;
    if (sel == 1) return '0;
    return $urandom_range(64 * (slot + 1), 16 * (slot + 1));
  endfunction

  // Request amounts aimed at a chosen slot: each slot that beats all earlier
  // ones is a target, and an amount just past the largest capacity misses.
  function automatic logic [CAP_W-1:0] pick_request_amount();
    int unsigned      lim;
    int unsigned      sel;
    int unsigned      pick;
    logic [CAP_W:0]   need;
    int unsigned      tgt_slot [$];
    logic [CAP_W:0]   tgt_need [$];
    lim = usable_slots();
    sel = $urandom_range(9, 0);
    if (lim == 0 || sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(15, 0);
    need = '0;
    for (int unsigned k = 0; k < lim; k++) begin
      if ({1'b0, slot_cap[k]} >= need) begin
        tgt_slot.push_back(k);
        tgt_need.push_back(need);
        need = {1'b0, slot_cap[k]} + 1;
      end
    end
    if (sel == 2 && !need[CAP_W]) return need[CAP_W-1:0];
    pick = $urandom_range(tgt_slot.size() - 1, 0);
    return $urandom_range(slot_cap[tgt_slot[pick]], tgt_need[pick][CAP_W-1:0]);
  endfunction

  // Every slot gets a capacity so that no request ever meets an unloaded one.
  task automatic test_fill_all_slots();
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      send_item(ffca_pkg::CMD_LOAD, SLOT_W'(i), pick_capacity(i));
    end
  endtask

  // A zero amount fits the first active slot and charges nothing.
  task automatic test_zero_amount();
    send_item(ffca_pkg::CMD_REQUEST, '1, '0);
    send_item(ffca_pkg::CMD_REQUEST, '0, '0);
  endtask

  // Full-scale capacities and amounts at both ends of the slot range.
  task automatic test_full_scale_amount();
    send_item(ffca_pkg::CMD_LOAD, SLOT_W'(SLOT_COUNT - 1), '1);
    send_item(ffca_pkg::CMD_REQUEST, '0, '1);
    send_item(ffca_pkg::CMD_REQUEST, '1, '1);
    send_item(ffca_pkg::CMD_LOAD, '0, '1);
    send_item(ffca_pkg::CMD_REQUEST, '0, '1);
    send_item(ffca_pkg::CMD_REQUEST, '0, CAP_W'(1));
    send_item(ffca_pkg::CMD_LOAD, '0, '0);
    send_item(ffca_pkg::CMD_REQUEST, '0, CAP_W'(1));
  endtask

  // Active counts of zero, one, one short of all, and beyond the slot total.
  task automatic test_active_count_edges();
    write_active_count('0);
    send_item(ffca_pkg::CMD_REQUEST, '0, '0);
    send_item(ffca_pkg::CMD_REQUEST, '0, CAP_W'(1));
    write_active_count(ACTIVE_W'(1));
    send_item(ffca_pkg::CMD_REQUEST, '0, '0);
    send_item(ffca_pkg::CMD_REQUEST, '0, '1);
    write_active_count('1);
    send_item(ffca_pkg::CMD_LOAD, SLOT_W'(SLOT_COUNT - 1), '1);
    send_item(ffca_pkg::CMD_REQUEST, '0, '1);
    write_active_count(ACTIVE_W'(SLOT_COUNT - 1));
    send_item(ffca_pkg::CMD_LOAD, SLOT_W'(SLOT_COUNT - 1), '1);
    send_item(ffca_pkg::CMD_REQUEST, '0, '1);
    write_active_count(ffca_pkg::ACTIVE_RESET);
  endtask

  // Mixed loads and aimed requests under one active count.
  task automatic test_random_traffic(input int unsigned item_total,
                                     input logic [ACTIVE_W-1:0] count);
    int unsigned slot;
    int unsigned lim;
    write_active_count(count);
    for (int unsigned n = 0; n < item_total; n++) begin
      lim = usable_slots();
      if ($urandom_range(3, 0) == 0) begin
        if (lim != 0 && $urandom_range(9, 0) < 7) slot = $urandom_range(lim - 1, 0);
        else slot = $urandom_range(SLOT_COUNT - 1, 0);
        send_item(ffca_pkg::CMD_LOAD, SLOT_W'(slot), pick_capacity(slot));
      end else begin
        send_item(ffca_pkg::CMD_REQUEST, SLOT_W'($urandom), pick_request_amount());
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ffca_pkg::CMD_LOAD;
    m_axis_tready  = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    active_count   = ffca_pkg::ACTIVE_RESET;
    foreach (slot_cap[i]) slot_cap[i] = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_all_slots();
    test_zero_amount();
    test_full_scale_amount();
    test_active_count_edges();

    test_random_traffic(RUN_ITEMS, ffca_pkg::ACTIVE_RESET);
    test_random_traffic(RUN_ITEMS, ACTIVE_W'($urandom_range(SLOT_COUNT, 1)));
    test_random_traffic(RUN_ITEMS, ACTIVE_W'(1));
    test_random_traffic(RUN_ITEMS, ACTIVE_W'($urandom_range(32, 2)));
    test_random_traffic(RUN_ITEMS, '1);
    quiet = 1'b1;
    test_random_traffic(RUN_ITEMS, ACTIVE_W'(SLOT_COUNT / 2));
    quiet = 1'b0;
    test_random_traffic(RUN_ITEMS + 2, ACTIVE_W'($urandom));

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/ffca_pkg.sv
hdl/first_fit_capacity_allocator.sv
verif/tb_top.sv
